// File: rtl/bcsc_pkg.sv
`default_nettype none
package bcsc_pkg;

  localparam int DATA_W        = 32;
  localparam int NUM_REGS      = 4;
  localparam int CFG_W         = 13;
  localparam int MEM_BYTES_DEF = 4096;

  // input commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_EXEC  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic CFG_MEM_IN_USE  = 1'b0;
  localparam logic CFG_STACK_FLOOR = 1'b1;

  // print kinds
  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_INT  = 2'd1;
  localparam logic [1:0] PK_STR  = 2'd2;

  // status bits
  localparam logic [7:0] F_BAD_ACCESS = 8'h01;
  localparam logic [7:0] F_BAD_INSTR  = 8'h02;
  localparam logic [7:0] F_BAD_REG    = 8'h04;
  localparam logic [7:0] F_OVERFLOW   = 8'h08;
  localparam logic [7:0] F_UNDERFLOW  = 8'h10;
  localparam logic [7:0] F_ABOVE      = 8'h20;
  localparam logic [7:0] F_EQUAL      = 8'h40;
  localparam logic [7:0] F_BELOW      = 8'h80;

  // instruction bytes
  localparam logic [7:0] OP_ADD      = 8'h01;
  localparam logic [7:0] OP_NEG      = 8'h02;
  localparam logic [7:0] OP_MUL      = 8'h03;
  localparam logic [7:0] OP_DIV      = 8'h04;
  localparam logic [7:0] OP_MOD      = 8'h05;
  localparam logic [7:0] OP_CMP      = 8'h10;
  localparam logic [7:0] OP_JA       = 8'h11;
  localparam logic [7:0] OP_JE       = 8'h12;
  localparam logic [7:0] OP_JB       = 8'h13;
  localparam logic [7:0] OP_JMP      = 8'h14;
  localparam logic [7:0] OP_CALL     = 8'h20;
  localparam logic [7:0] OP_RET      = 8'h21;
  localparam logic [7:0] OP_LOAD     = 8'h30;
  localparam logic [7:0] OP_STORE    = 8'h31;
  localparam logic [7:0] OP_CONST    = 8'h32;
  localparam logic [7:0] OP_RLOAD    = 8'h33;
  localparam logic [7:0] OP_RSTORE   = 8'h34;
  localparam logic [7:0] OP_HALT     = 8'h40;
  localparam logic [7:0] OP_INT      = 8'h41;
  localparam logic [7:0] OP_NOP      = 8'h42;
  localparam logic [7:0] OP_PUSH     = 8'h50;
  localparam logic [7:0] OP_PUSH_ALL = 8'h51;
  localparam logic [7:0] OP_POP      = 8'h52;
  localparam logic [7:0] OP_POP_ALL  = 8'h53;
  localparam logic [7:0] OP_LSP      = 8'h54;

  // instruction length in bytes, zero for an unknown byte
  function automatic logic [2:0] op_len(input logic [7:0] op);
    logic [2:0] len;
    case (op) inside
      OP_ADD, OP_MUL, OP_DIV, OP_MOD, OP_CMP, OP_RLOAD, OP_RSTORE: len = 3'd3;
      OP_NEG, OP_INT, OP_PUSH, OP_POP, OP_LSP:                    len = 3'd2;
      OP_JA, OP_JE, OP_JB, OP_JMP, OP_CALL:                       len = 3'd5;
      OP_LOAD, OP_STORE, OP_CONST:                                len = 3'd6;
      OP_RET, OP_HALT, OP_NOP, OP_PUSH_ALL, OP_POP_ALL:           len = 3'd1;
      default:                                                    len = 3'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// File: rtl/bytecode_vm_step_core.sv
// Byte-coded stack machine that takes one item per beat: write a program byte, read
// a byte back, or execute one instruction at the program counter. Program bytes, data
// and the stack share one byte-wide memory with a single read and a single write port,
// so everything is moved one byte per cycle. An execute beat fetches six bytes at the
// counter, then decodes and reads the two registers for a register instruction; every
// stack or memory word adds a four-byte read or write, push-all and pop-all repeat that
// for each of the four registers, and divide and modulo wait for the serial divider.
// After reset the memory is cleared one byte per cycle, all MEM_BYTES bytes (4096 by
// default), before the first beat is taken; configuration writes are taken at any
// time but are meant for an idle block.
// MEM_BYTES must be a power of two, since byte addresses wrap at that size.
`default_nettype none
module bytecode_vm_step_core import bcsc_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_opcode,
  input  wire logic [11:0]             in_byte_address,
  input  wire logic [7:0]              in_byte_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_halted,
  output logic signed [DATA_W-1:0]     out_program_count,
  output logic      [7:0]              out_status_bits,
  output logic      [1:0]              out_print_kind,
  output logic signed [DATA_W-1:0]     out_print_value,
  output logic      [7:0]              out_read_value,
  input  wire logic                    cfg_we,
  input  wire logic [0:0]              cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_wdata
);

  localparam int AW = $clog2(MEM_BYTES);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_BREAD = 13'b0000000000100,
    S_FETCH = 13'b0000000001000,
    S_DEC   = 13'b0000000010000,
    S_REGB  = 13'b0000000100000,
    S_EXEC  = 13'b0000001000000,
    S_DIV   = 13'b0000010000000,
    S_PREP  = 13'b0000100000000,
    S_WRD   = 13'b0001000000000,
    S_WWR   = 13'b0010000000000,
    S_POST  = 13'b0100000000000,
    S_RESP  = 13'b1000000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [DATA_W-1:0] pc_r, pc_nxt;
  logic [DATA_W-1:0] sp_r, sp_nxt;
  logic [7:0]        flags_r, flags_nxt;
  logic              stopped_r, stopped_nxt;
  logic [CFG_W-1:0]  miu_r, miu_nxt;
  logic [CFG_W-1:0]  floor_r, floor_nxt;
  logic [DATA_W-1:0] regs_r [NUM_REGS];
  logic [47:0]       ibuf_r, ibuf_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [DATA_W-1:0] ra_r, ra_nxt;
  logic [DATA_W-1:0] rb_r, rb_nxt;
  logic [AW-1:0]     wbase_r, wbase_nxt;
  logic [DATA_W-1:0] wdata_r, wdata_nxt;
  logic [DATA_W-1:0] rword_r, rword_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [DATA_W-1:0] pval_r, pval_nxt;
  logic [7:0]        rdv_r, rdv_nxt;
  logic              out_valid_r;
  logic              out_load;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [7:0]        mem_rdata;

  logic              rf_we;
  logic [1:0]        rf_widx;
  logic [DATA_W-1:0] rf_wdata;
  logic [1:0]        rf_ridx;
  logic [DATA_W-1:0] rf_rdata;

  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_dividend, div_divisor, div_quot, div_rem;

  logic [CFG_W-1:0]  size_w;
  logic [7:0]        op, a_b, b_b;
  logic [DATA_W-1:0] imm1, imm2;
  logic [2:0]        len;
  logic [DATA_W-1:0] next_pc;
  logic              one, two;
  logic              pc_bad, fit_bad;
  logic signed [33:0] sp_s, size_s, floor_s, avail_s, occ_s;
  logic              sp_empty, sp_low;
  logic              in_fire;
  logic [DATA_W-1:0] sp_m4;
  logic [4:0]        step_off;

  assign size_w = ({19'd0, miu_r} < 32'(MEM_BYTES)) ? miu_r : CFG_W'(MEM_BYTES);

  assign op      = ibuf_r[7:0];
  assign a_b     = ibuf_r[15:8];
  assign b_b     = ibuf_r[23:16];
  assign imm1    = ibuf_r[39:8];
  assign imm2    = ibuf_r[47:16];
  assign len     = op_len(op);
  assign next_pc = pc_r + DATA_W'(len);
  assign one     = a_b < 8'(NUM_REGS);
  assign two     = one && (b_b < 8'(NUM_REGS));

  assign pc_bad  = pc_r[DATA_W-1] || (pc_r >= {19'd0, size_w});
  assign fit_bad = ({1'b0, pc_r[CFG_W-1:0]} + 14'(len)) > {1'b0, size_w};

  assign sp_s     = {{2{sp_r[DATA_W-1]}}, sp_r};
  assign size_s   = {21'd0, size_w};
  assign floor_s  = {21'd0, floor_r};
  assign avail_s  = sp_s - floor_s;
  assign occ_s    = size_s - sp_s;
  assign sp_empty = sp_s >= size_s;
  assign sp_low   = sp_s <= floor_s;
  assign sp_m4    = sp_r - 32'd4;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign rf_rdata = regs_r[rf_ridx];

  // word offset for the push-all and pop-all loops
  assign step_off = (op == OP_PUSH_ALL) ? {1'b0, step_r, 2'b00} + 5'd4
                                        : {1'b0, step_r, 2'b00};

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pc_nxt      = pc_r;
    sp_nxt      = sp_r;
    flags_nxt   = flags_r;
    stopped_nxt = stopped_r;
    miu_nxt     = miu_r;
    floor_nxt   = floor_r;
    ibuf_nxt    = ibuf_r;
    cnt_nxt     = cnt_r;
    step_nxt    = step_r;
    ra_nxt      = ra_r;
    rb_nxt      = rb_r;
    wbase_nxt   = wbase_r;
    wdata_nxt   = wdata_r;
    rword_nxt   = rword_r;
    kind_nxt    = kind_r;
    pval_nxt    = pval_r;
    rdv_nxt     = rdv_r;
    mem_we      = 1'b0;
    mem_waddr   = wbase_r + AW'(cnt_r);
    mem_wdata   = wdata_r[7:0];
    mem_raddr   = wbase_r + AW'(cnt_r);
    rf_we       = 1'b0;
    rf_widx     = b_b[1:0];
    rf_wdata    = '0;
    rf_ridx     = a_b[1:0];
    div_start   = 1'b0;
    div_dividend = rb_r;
    div_divisor  = ra_r;
    out_load    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = 8'h00;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(MEM_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = AW'(in_byte_address);
        mem_waddr = AW'(in_byte_address);
        mem_wdata = in_byte_value;
        if (in_fire) begin
          kind_nxt = PK_NONE;
          pval_nxt = '0;
          rdv_nxt  = '0;
          cnt_nxt  = '0;
          unique case (in_opcode)
            CMD_WRITE: begin
              mem_we    = 1'b1;
              state_nxt = S_RESP;
            end
            CMD_READ: state_nxt = S_BREAD;
            CMD_EXEC: begin
              if (stopped_r) begin
                state_nxt = S_RESP;
              end else if (pc_bad) begin
                flags_nxt   = flags_r | F_BAD_ACCESS;
                stopped_nxt = 1'b1;
                state_nxt   = S_RESP;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_BREAD: begin
        rdv_nxt   = mem_rdata;
        state_nxt = S_RESP;
      end
      S_FETCH: begin
        mem_raddr = pc_r[AW-1:0] + AW'(cnt_r);
        if (cnt_r != 3'd0) begin
          ibuf_nxt = {mem_rdata, ibuf_r[47:8]};
        end
        if (cnt_r == 3'd6) begin
          cnt_nxt   = '0;
          state_nxt = S_DEC;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_DEC: begin
        rf_ridx = a_b[1:0];
        ra_nxt  = rf_rdata;
        if (len == 3'd0) begin
          flags_nxt   = flags_r | F_BAD_INSTR;
          stopped_nxt = 1'b1;
          state_nxt   = S_RESP;
        end else if (op == OP_HALT) begin
          stopped_nxt = 1'b1;
          state_nxt   = S_RESP;
        end else if (fit_bad) begin
          flags_nxt   = flags_r | F_BAD_ACCESS;
          stopped_nxt = 1'b1;
          state_nxt   = S_RESP;
        end else begin
          state_nxt = S_REGB;
        end
      end
      S_REGB: begin
        rf_ridx   = b_b[1:0];
        rb_nxt    = rf_rdata;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        cnt_nxt   = '0;
        step_nxt  = '0;
        pc_nxt    = next_pc;
        case (op) inside
          OP_ADD, OP_MUL, OP_CMP: begin
            if (!two) begin
              pc_nxt      = pc_r;
              flags_nxt   = flags_r | F_BAD_REG;
              stopped_nxt = 1'b1;
            end else if (op == OP_ADD) begin
              rf_we    = 1'b1;
              rf_wdata = ra_r + rb_r;
            end else if (op == OP_MUL) begin
              rf_we    = 1'b1;
              rf_wdata = DATA_W'(ra_r * rb_r);
            end else begin
              flags_nxt = flags_r & ~(F_ABOVE | F_EQUAL | F_BELOW);
              if ($signed(ra_r) < $signed(rb_r)) begin
                flags_nxt = flags_nxt | F_BELOW;
              end else if ($signed(ra_r) > $signed(rb_r)) begin
                flags_nxt = flags_nxt | F_ABOVE;
              end else begin
                flags_nxt = flags_nxt | F_EQUAL;
              end
            end
          end
          OP_DIV, OP_MOD: begin
            pc_nxt = pc_r;
            if (!two) begin
              flags_nxt   = flags_r | F_BAD_REG;
              stopped_nxt = 1'b1;
            end else if ((op == OP_DIV) ? (ra_r == '0) : (rb_r == '0)) begin
              flags_nxt   = flags_r | F_BAD_ACCESS;
              stopped_nxt = 1'b1;
            end else begin
              div_start    = 1'b1;
              div_dividend = (op == OP_DIV) ? rb_r : ra_r;
              div_divisor  = (op == OP_DIV) ? ra_r : rb_r;
              state_nxt    = S_DIV;
            end
          end
          OP_NEG, OP_CONST, OP_LSP: begin
            if (!one) begin
              pc_nxt      = pc_r;
              flags_nxt   = flags_r | F_BAD_REG;
              stopped_nxt = 1'b1;
            end else begin
              rf_we   = 1'b1;
              rf_widx = a_b[1:0];
              rf_wdata = (op == OP_NEG) ? -ra_r : ((op == OP_CONST) ? imm2 : sp_r);
            end
          end
          OP_JA:  pc_nxt = flags_r[5] ? imm1 : next_pc;
          OP_JE:  pc_nxt = flags_r[6] ? imm1 : next_pc;
          OP_JB:  pc_nxt = flags_r[7] ? imm1 : next_pc;
          OP_JMP: pc_nxt = imm1;
          OP_NOP: pc_nxt = next_pc;
          OP_CALL: begin
            pc_nxt = pc_r;
            if (avail_s < 34'sd4) begin
              flags_nxt   = flags_r | F_OVERFLOW;
              stopped_nxt = 1'b1;
            end else begin
              sp_nxt    = sp_m4;
              wbase_nxt = sp_m4[AW-1:0];
              wdata_nxt = next_pc;
              state_nxt = S_WWR;
            end
          end
          OP_RET, OP_INT: begin
            pc_nxt = pc_r;
            if (sp_empty) begin
              flags_nxt   = flags_r | F_UNDERFLOW;
              stopped_nxt = 1'b1;
            end else if (op == OP_INT && a_b != 8'd1 && a_b != 8'd2) begin
              stopped_nxt = 1'b1;
            end else begin
              sp_nxt    = sp_r + 32'd4;
              wbase_nxt = sp_r[AW-1:0];
              state_nxt = S_WRD;
            end
          end
          OP_LOAD, OP_STORE: begin
            pc_nxt = pc_r;
            if (!one) begin
              flags_nxt   = flags_r | F_BAD_REG;
              stopped_nxt = 1'b1;
            end else begin
              wbase_nxt = imm2[AW-1:0];
              wdata_nxt = ra_r;
              state_nxt = (op == OP_LOAD) ? S_WRD : S_WWR;
            end
          end
          OP_RLOAD, OP_RSTORE: begin
            pc_nxt = pc_r;
            if (!two) begin
              flags_nxt   = flags_r | ((op == OP_RLOAD) ? F_BAD_REG : F_BAD_ACCESS);
              stopped_nxt = 1'b1;
            end else begin
              wbase_nxt = (op == OP_RLOAD) ? ra_r[AW-1:0] : rb_r[AW-1:0];
              wdata_nxt = ra_r;
              state_nxt = (op == OP_RLOAD) ? S_WRD : S_WWR;
            end
          end
          OP_PUSH, OP_POP: begin
            pc_nxt = pc_r;
            if ((op == OP_PUSH) ? sp_low : sp_empty) begin
              stopped_nxt = 1'b1;
            end else if (!one) begin
              flags_nxt   = flags_r | F_BAD_REG;
              stopped_nxt = 1'b1;
            end else if (op == OP_PUSH) begin
              sp_nxt    = sp_m4;
              wbase_nxt = sp_m4[AW-1:0];
              wdata_nxt = ra_r;
              state_nxt = S_WWR;
            end else begin
              sp_nxt    = sp_r + 32'd4;
              wbase_nxt = sp_r[AW-1:0];
              state_nxt = S_WRD;
            end
          end
          OP_PUSH_ALL, OP_POP_ALL: begin
            pc_nxt = pc_r;
            if ((op == OP_PUSH_ALL) ? (avail_s < 34'sd16) : (occ_s < 34'sd16)) begin
              flags_nxt   = flags_r | ((op == OP_PUSH_ALL) ? F_OVERFLOW : F_UNDERFLOW);
              stopped_nxt = 1'b1;
            end else begin
              state_nxt = S_PREP;
            end
          end
          default: begin
            pc_nxt      = pc_r;
            flags_nxt   = flags_r | F_BAD_INSTR;
            stopped_nxt = 1'b1;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          rf_we     = 1'b1;
          rf_wdata  = (op == OP_DIV) ? div_quot : div_rem;
          pc_nxt    = next_pc;
          state_nxt = S_RESP;
        end
      end
      S_PREP: begin
        rf_ridx = step_r;
        cnt_nxt = '0;
        if (op == OP_PUSH_ALL) begin
          wbase_nxt = sp_r[AW-1:0] - AW'(step_off);
          wdata_nxt = rf_rdata;
          state_nxt = S_WWR;
        end else begin
          wbase_nxt = sp_r[AW-1:0] + AW'(step_off);
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        if (cnt_r != 3'd0) begin
          rword_nxt = {mem_rdata, rword_r[DATA_W-1:8]};
        end
        if (cnt_r == 3'd4) begin
          cnt_nxt   = '0;
          state_nxt = S_POST;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_WWR: begin
        mem_we    = 1'b1;
        wdata_nxt = wdata_r >> 8;
        if (cnt_r == 3'd3) begin
          cnt_nxt   = '0;
          state_nxt = S_POST;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_POST: begin
        state_nxt = S_RESP;
        pc_nxt    = next_pc;
        case (op) inside
          OP_CALL: pc_nxt = imm1;
          OP_RET:  pc_nxt = rword_r;
          OP_LOAD, OP_POP: begin
            rf_we    = 1'b1;
            rf_widx  = a_b[1:0];
            rf_wdata = rword_r;
          end
          OP_RLOAD: begin
            rf_we    = 1'b1;
            rf_wdata = rword_r;
          end
          OP_INT: begin
            kind_nxt = a_b[1:0];
            pval_nxt = rword_r;
          end
          OP_PUSH_ALL, OP_POP_ALL: begin
            if (op == OP_POP_ALL) begin
              rf_we    = 1'b1;
              rf_widx  = 2'd3 - step_r;
              rf_wdata = rword_r;
            end
            if (step_r == 2'd3) begin
              sp_nxt = (op == OP_PUSH_ALL) ? sp_r - 32'd16 : sp_r + 32'd16;
            end else begin
              pc_nxt    = pc_r;
              step_nxt  = step_r + 2'd1;
              state_nxt = S_PREP;
            end
          end
          default: pc_nxt = next_pc;
        endcase
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MEM_IN_USE: begin
          miu_nxt = cfg_wdata;
          sp_nxt  = {19'd0, cfg_wdata};
        end
        CFG_STACK_FLOOR: floor_nxt = cfg_wdata;
        default: floor_nxt = floor_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      sp_r        <= 32'(MEM_BYTES_DEF);
      flags_r     <= '0;
      stopped_r   <= 1'b0;
      miu_r       <= CFG_W'(MEM_BYTES_DEF);
      floor_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pc_r        <= pc_nxt;
      sp_r        <= sp_nxt;
      flags_r     <= flags_nxt;
      stopped_r   <= stopped_nxt;
      miu_r       <= miu_nxt;
      floor_r     <= floor_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (rf_we) begin
        regs_r[rf_widx] <= rf_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ibuf_r  <= ibuf_nxt;
    cnt_r   <= cnt_nxt;
    step_r  <= step_nxt;
    ra_r    <= ra_nxt;
    rb_r    <= rb_nxt;
    wbase_r <= wbase_nxt;
    wdata_r <= wdata_nxt;
    rword_r <= rword_nxt;
    kind_r  <= kind_nxt;
    pval_r  <= pval_nxt;
    rdv_r   <= rdv_nxt;
    if (out_load) begin
      out_halted        <= stopped_r;
      out_program_count <= pc_r;
      out_status_bits   <= flags_r;
      out_print_kind    <= kind_r;
      out_print_value   <= pval_r;
      out_read_value    <= rdv_r;
    end
  end

  assign out_valid = out_valid_r;

  bcsc_ram #(
    .Width(8),
    .Depth(MEM_BYTES)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  bcsc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quot    (div_quot),
    .rem     (div_rem)
  );

endmodule
`default_nettype wire

// File: rtl/bcsc_ram.sv
`default_nettype none
module bcsc_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/bcsc_div.sv
`default_nettype none
module bcsc_div import bcsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic      [DATA_W-1:0] quot,
  output logic      [DATA_W-1:0] rem
);

  localparam int CntW = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [CntW-1:0]   cnt_r;
  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] r_r;
  logic [DATA_W-1:0] d_r;
  logic              qneg_r;
  logic              rneg_r;
  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;
  logic              ge;

  // one quotient bit per cycle, restoring, on magnitudes
  assign shifted = {r_r, q_r[DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, d_r};
  assign ge      = ~diff[DATA_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= dividend[DATA_W-1] ? -dividend : dividend;
      d_r    <= divisor[DATA_W-1] ? -divisor : divisor;
      r_r    <= '0;
      qneg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      rneg_r <= dividend[DATA_W-1];
    end else if (busy_r) begin
      q_r <= {q_r[DATA_W-2:0], ge};
      r_r <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = qneg_r ? -q_r : q_r;
  assign rem  = rneg_r ? -r_r : r_r;

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import bcsc_pkg::*;

  typedef struct packed {
    logic        halted;
    logic [31:0] pc;
    logic [7:0]  status;
    logic [1:0]  kind;
    logic [31:0] pval;
    logic [7:0]  rdv;
  } step_result_t;

  typedef struct {
    logic [1:0]   cmd;
    logic [11:0]  addr;
    logic [7:0]   val;
    bit           typed;
    step_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = CMD_WRITE;
  logic [11:0] in_byte_address = '0;
  logic [7:0]  in_byte_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_halted;
  logic signed [DATA_W-1:0] out_program_count;
  logic [7:0]  out_status_bits;
  logic [1:0]  out_print_kind;
  logic signed [DATA_W-1:0] out_print_value;
  logic [7:0]  out_read_value;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  bytecode_vm_step_core dut (.*);

  always #5 clk = ~clk;

  // machine copy
  logic [7:0]  vm_mem [4096];
  logic [31:0] vm_reg [4];
  logic [31:0] vm_pc, vm_sp;
  logic [7:0]  vm_flags;
  bit          vm_stopped;
  logic [31:0] vm_mem_size, vm_floor;

  step_result_t pending_steps[$];
  dir_row_t     dir_rows[$];
  int  mismatches = 0;
  int  n_items = 0, n_results = 0, n_exec = 0, n_prints = 0;
  bit  quiet = 1'b0;

  function automatic logic [2:0] op_bytes(logic [7:0] op);
    case (op)
      OP_ADD, OP_MUL, OP_DIV, OP_MOD, OP_CMP, OP_RLOAD, OP_RSTORE: return 3'd3;
      OP_NEG, OP_INT, OP_PUSH, OP_POP, OP_LSP: return 3'd2;
      OP_JA, OP_JE, OP_JB, OP_JMP, OP_CALL: return 3'd5;
      OP_LOAD, OP_STORE, OP_CONST: return 3'd6;
      OP_RET, OP_HALT, OP_NOP, OP_PUSH_ALL, OP_POP_ALL: return 3'd1;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [31:0] mem_word(logic [31:0] a);
    logic [31:0] a1, a2, a3;
    a1 = a + 32'd1;
    a2 = a + 32'd2;
    a3 = a + 32'd3;
    return {vm_mem[a3[11:0]], vm_mem[a2[11:0]], vm_mem[a1[11:0]], vm_mem[a[11:0]]};
  endfunction

  task automatic put_word(logic [31:0] a, logic [31:0] v);
    logic [31:0] ai;
    for (int i = 0; i < 4; i++) begin
      ai = a + i;
      vm_mem[ai[11:0]] = v[8*i +: 8];
    end
  endtask

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint mem_span();
    return (vm_mem_size < 4096) ? longint'(vm_mem_size) : 64'sd4096;
  endfunction

  // one instruction; stop set when the machine halts
  task automatic run_instr(output bit stop, output logic [1:0] kind, output logic [31:0] pv);
    longint sz, pcs, sp, avail, occ, sa, sb;
    logic [7:0] op, a, b;
    logic [2:0] len;
    logic [31:0] nxt, imm1, imm2;
    bit one, two;
    stop = 1'b0;
    kind = PK_NONE;
    pv = '0;
    sz = mem_span();
    pcs = sx(vm_pc);
    if (pcs < 0 || pcs >= sz) begin
      vm_flags |= F_BAD_ACCESS; stop = 1'b1; return;
    end
    op = vm_mem[vm_pc[11:0]];
    len = op_bytes(op);
    if (len == 0) begin
      vm_flags |= F_BAD_INSTR; stop = 1'b1; return;
    end
    if (op == OP_HALT) begin
      stop = 1'b1; return;
    end
    if (pcs + len > sz) begin
      vm_flags |= F_BAD_ACCESS; stop = 1'b1; return;
    end
    imm1 = mem_word(vm_pc + 1);
    imm2 = mem_word(vm_pc + 2);
    a = imm1[7:0];
    b = imm2[7:0];
    one = a < NUM_REGS;
    two = one && b < NUM_REGS;
    sp = sx(vm_sp);
    avail = sp - longint'(vm_floor);
    occ = sz - sp;
    nxt = vm_pc + len;
    case (op)
      OP_ADD, OP_NEG, OP_MUL, OP_DIV, OP_MOD, OP_CMP, OP_RLOAD: begin
        if ((op == OP_NEG) ? !one : !two) begin
          vm_flags |= F_BAD_REG; stop = 1'b1; return;
        end
        case (op)
          OP_ADD: vm_reg[b[1:0]] = vm_reg[b[1:0]] + vm_reg[a[1:0]];
          OP_NEG: vm_reg[a[1:0]] = 32'd0 - vm_reg[a[1:0]];
          OP_MUL: vm_reg[b[1:0]] = vm_reg[b[1:0]] * vm_reg[a[1:0]];
          OP_DIV: begin
            if (vm_reg[a[1:0]] == 0) begin
              vm_flags |= F_BAD_ACCESS; stop = 1'b1; return;
            end
            sa = sx(vm_reg[b[1:0]]) / sx(vm_reg[a[1:0]]);
            vm_reg[b[1:0]] = sa[31:0];
          end
          OP_MOD: begin
            if (vm_reg[b[1:0]] == 0) begin
              vm_flags |= F_BAD_ACCESS; stop = 1'b1; return;
            end
            sa = sx(vm_reg[a[1:0]]) % sx(vm_reg[b[1:0]]);
            vm_reg[b[1:0]] = sa[31:0];
          end
          OP_CMP: begin
            sa = sx(vm_reg[a[1:0]]);
            sb = sx(vm_reg[b[1:0]]);
            vm_flags &= ~(F_ABOVE | F_EQUAL | F_BELOW);
            vm_flags |= (sa < sb) ? F_BELOW : ((sa > sb) ? F_ABOVE : F_EQUAL);
          end
          default: vm_reg[b[1:0]] = mem_word(vm_reg[a[1:0]]);
        endcase
      end
      OP_JA: if (vm_flags & F_ABOVE) nxt = imm1;
      OP_JE: if (vm_flags & F_EQUAL) nxt = imm1;
      OP_JB: if (vm_flags & F_BELOW) nxt = imm1;
      OP_JMP: nxt = imm1;
      OP_CALL: begin
        if (avail < 4) begin
          vm_flags |= F_OVERFLOW; stop = 1'b1; return;
        end
        vm_sp -= 4;
        put_word(vm_sp, vm_pc + len);
        nxt = imm1;
      end
      OP_RET: begin
        if (sp >= sz) begin
          vm_flags |= F_UNDERFLOW; stop = 1'b1; return;
        end
        nxt = mem_word(vm_sp);
        vm_sp += 4;
      end
      OP_LOAD, OP_STORE, OP_CONST, OP_LSP: begin
        if (!one) begin
          vm_flags |= F_BAD_REG; stop = 1'b1; return;
        end
        case (op)
          OP_LOAD:  vm_reg[a[1:0]] = mem_word(imm2);
          OP_STORE: put_word(imm2, vm_reg[a[1:0]]);
          OP_CONST: vm_reg[a[1:0]] = imm2;
          default:  vm_reg[a[1:0]] = vm_sp;
        endcase
      end
      OP_RSTORE: begin
        // bad index here reports bad access
        if (!two) begin
          vm_flags |= F_BAD_ACCESS; stop = 1'b1; return;
        end
        put_word(vm_reg[b[1:0]], vm_reg[a[1:0]]);
      end
      OP_INT: begin
        if (sp >= sz) begin
          vm_flags |= F_UNDERFLOW; stop = 1'b1; return;
        end
        if (a != PK_INT && a != PK_STR) begin
          stop = 1'b1; return;
        end
        kind = a[1:0];
        pv = mem_word(vm_sp);
        vm_sp += 4;
      end
      OP_NOP: ;
      OP_PUSH: begin
        if (sp <= longint'(vm_floor)) begin
          stop = 1'b1; return;
        end
        if (!one) begin
          vm_flags |= F_BAD_REG; stop = 1'b1; return;
        end
        put_word(vm_sp - 4, vm_reg[a[1:0]]);
        vm_sp -= 4;
      end
      OP_PUSH_ALL: begin
        if (avail < 16) begin
          vm_flags |= F_OVERFLOW; stop = 1'b1; return;
        end
        for (int i = 0; i < 4; i++) begin
          vm_sp -= 4;
          put_word(vm_sp, vm_reg[i]);
        end
      end
      OP_POP: begin
        if (sp >= sz) begin
          stop = 1'b1; return;
        end
        if (!one) begin
          vm_flags |= F_BAD_REG; stop = 1'b1; return;
        end
        vm_reg[a[1:0]] = mem_word(vm_sp);
        vm_sp += 4;
      end
      default: begin // pop all
        if (occ < 16) begin
          vm_flags |= F_UNDERFLOW; stop = 1'b1; return;
        end
        for (int i = 0; i < 4; i++) vm_reg[3-i] = mem_word(vm_sp + 4*i);
        vm_sp += 16;
      end
    endcase
    vm_pc = nxt;
  endtask

  task automatic predict_step(logic [1:0] cmd, logic [11:0] addr, logic [7:0] val,
                              output step_result_t r);
    bit stop;
    logic [1:0] kind;
    logic [31:0] pv;
    r = '0;
    if (cmd == CMD_WRITE) vm_mem[addr] = val;
    else if (cmd == CMD_READ) r.rdv = vm_mem[addr];
    else if (cmd == CMD_EXEC && !vm_stopped) begin
      run_instr(stop, kind, pv);
      if (stop) vm_stopped = 1'b1;
      r.kind = kind;
      r.pval = pv;
    end
    r.halted = vm_stopped;
    r.pc = vm_pc;
    r.status = vm_flags;
  endtask

  task automatic send_beat(logic [1:0] cmd, logic [11:0] addr, logic [7:0] val,
                           bit typed = 1'b0, step_result_t typed_res = '0);
    step_result_t r;
    in_valid <= 1'b1;
    in_opcode <= cmd;
    in_byte_address <= addr;
    in_byte_value <= val;
    do @(posedge clk); while (!in_ready);
    predict_step(cmd, addr, val, r);
    pending_steps.push_back(typed ? typed_res : r);
    n_items++;
    if (cmd == CMD_EXEC) n_exec++;
    if (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [CFG_W-1:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MEM_IN_USE) begin
      vm_mem_size = 32'(data);
      vm_sp = 32'(data);
    end else begin
      vm_floor = 32'(data);
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h0;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 9);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 24))
      0: return OP_ADD;    1: return OP_NEG;    2: return OP_MUL;     3: return OP_DIV;
      4: return OP_MOD;    5: return OP_CMP;    6: return OP_JA;      7: return OP_JE;
      8: return OP_JB;     9: return OP_JMP;    10: return OP_CALL;   11: return OP_RET;
      12: return OP_LOAD;  13: return OP_STORE; 14: return OP_CONST;  15: return OP_RLOAD;
      16: return OP_RSTORE; 17: return OP_HALT; 18: return OP_INT;    19: return OP_NOP;
      20: return OP_PUSH;  21: return OP_PUSH_ALL; 22: return OP_POP; 23: return OP_POP_ALL;
      default: return OP_LSP;
    endcase
  endfunction

  task automatic noise_beat();
    logic [1:0] cmd;
    case ($urandom_range(0, 2))
      0: cmd = CMD_WRITE;
      1: cmd = CMD_READ;
      default: cmd = 2'd3;
    endcase
    send_beat(cmd, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
  endtask

  // write an instruction at pc and execute it; wild allows faults
  task automatic program_and_run(bit wild);
    logic [7:0] op, ra, rb;
    logic [31:0] imm, tgt, pa;
    logic [7:0] code [6];
    longint sz, sp, avail, occ;
    int n;
    sz = mem_span();
    sp = sx(vm_sp);
    avail = sp - longint'(vm_floor);
    occ = sz - sp;
    op = pick_op();
    ra = wild ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 3));
    rb = wild ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 3));
    imm = pick_word();
    tgt = $urandom_range(0, 170);
    if (wild) begin
      if ($urandom_range(0, 1)) op = 8'($urandom_range(0, 255));
      tgt = $urandom;
    end else begin
      if (vm_pc > 180) op = OP_JMP;
      case (op)
        OP_DIV:      if (vm_reg[ra[1:0]] == 0) op = OP_CONST;
        OP_MOD:      if (vm_reg[rb[1:0]] == 0) op = OP_CONST;
        OP_CALL:     if (avail < 4) op = OP_NOP;
        OP_RET:      if (sp >= sz || mem_word(vm_sp) > 170) op = OP_NOP;
        OP_INT:      if (sp >= sz) op = OP_NOP; else ra = 8'($urandom_range(1, 2));
        OP_PUSH:     if (sp <= longint'(vm_floor)) op = OP_NOP;
        OP_PUSH_ALL: if (avail < 16) op = OP_NOP;
        OP_POP:      if (sp >= sz) op = OP_NOP;
        OP_POP_ALL:  if (occ < 16) op = OP_NOP;
        OP_HALT:     op = OP_CMP;
        default: ;
      endcase
    end
    code[0] = op;
    code[1] = ra;
    code[2] = rb;
    code[3] = 8'($urandom);
    code[4] = 8'($urandom);
    code[5] = 8'($urandom);
    if (op inside {OP_JA, OP_JE, OP_JB, OP_JMP, OP_CALL})
      for (int i = 0; i < 4; i++) code[1+i] = tgt[8*i +: 8];
    else if (op inside {OP_LOAD, OP_STORE, OP_CONST})
      for (int i = 0; i < 4; i++) code[2+i] = imm[8*i +: 8];
    n = wild ? 6 : int'(op_bytes(op));
    for (int i = 0; i < n; i++) begin
      pa = vm_pc + i;
      send_beat(CMD_WRITE, pa[11:0], code[i]);
    end
    send_beat(CMD_EXEC, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
  endtask

  task automatic random_phase(int items);
    int stop_at;
    stop_at = n_items + items;
    while (n_items < stop_at) begin
      if ($urandom_range(0, 99) < 15) noise_beat();
      else program_and_run(1'b0);
    end
  endtask

  task automatic add_row(logic [1:0] cmd, logic [11:0] addr, logic [7:0] val,
                         bit typed = 1'b0, logic [31:0] pc = '0, logic [7:0] rdv = '0);
    dir_row_t row;
    row.cmd = cmd;
    row.addr = addr;
    row.val = val;
    row.typed = typed;
    row.res = '0;
    row.res.pc = pc;
    row.res.rdv = rdv;
    dir_rows.push_back(row);
  endtask

  // result checker
  always @(posedge clk) begin
    step_result_t want, got;
    if (rst_n) out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 6);
    if (out_valid && out_ready) begin
      got = {out_halted, out_program_count, out_status_bits, out_print_kind,
             out_print_value, out_read_value};
      n_results++;
      if (out_print_kind != PK_NONE) n_prints++;
      if (pending_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %0h", got);
      end else begin
        want = pending_steps.pop_front();
        if (want != got) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: exp halt=%0b pc=%0h st=%0h pk=%0d pv=%0h rd=%0h | got halt=%0b pc=%0h st=%0h pk=%0d pv=%0h rd=%0h",
                     n_results, want.halted, want.pc, want.status, want.kind, want.pval,
                     want.rdv, got.halted, got.pc, got.status, got.kind, got.pval, got.rdv);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** bytecode_vm_step_core: FAILED **");
    $finish;
  end

  initial begin
    int tries;
    foreach (vm_mem[i]) vm_mem[i] = '0;
    foreach (vm_reg[i]) vm_reg[i] = '0;
    vm_pc = '0;
    vm_flags = '0;
    vm_stopped = 1'b0;
    vm_mem_size = 4096;
    vm_sp = 4096;
    vm_floor = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, unused command, then a min / -1 divide
    add_row(CMD_READ, 12'h000, 8'h00, 1'b1);
    add_row(2'd3, 12'hfff, 8'hff, 1'b1);
    add_row(CMD_WRITE, 12'hfff, 8'hff, 1'b1);
    add_row(CMD_READ, 12'hfff, 8'h00, 1'b1, 32'd0, 8'hff);
    add_row(CMD_WRITE, 12'h000, OP_NOP, 1'b1);
    add_row(CMD_EXEC, 12'h000, 8'h00, 1'b1, 32'd1);
    add_row(CMD_WRITE, 12'd1, OP_CONST);
    add_row(CMD_WRITE, 12'd2, 8'd0);
    add_row(CMD_WRITE, 12'd3, 8'h00);
    add_row(CMD_WRITE, 12'd4, 8'h00);
    add_row(CMD_WRITE, 12'd5, 8'h00);
    add_row(CMD_WRITE, 12'd6, 8'h80);
    add_row(CMD_EXEC, 12'd0, 8'd0);
    add_row(CMD_WRITE, 12'd7, OP_CONST);
    add_row(CMD_WRITE, 12'd8, 8'd1);
    for (int i = 9; i < 13; i++) add_row(CMD_WRITE, 12'(i), 8'hff);
    add_row(CMD_EXEC, 12'd0, 8'd0);
    add_row(CMD_WRITE, 12'd13, OP_DIV);
    add_row(CMD_WRITE, 12'd14, 8'd1);
    add_row(CMD_WRITE, 12'd15, 8'd0);
    add_row(CMD_EXEC, 12'hfff, 8'hff);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].val,
                dir_rows[i].typed, dir_rows[i].res);

    random_phase(60);
    quiet = 1'b1;
    random_phase(80);
    quiet = 1'b0;
    // hold off until every outstanding result is back
    drain();
    random_phase(40);

    write_cfg(CFG_MEM_IN_USE, 13'd256);
    write_cfg(CFG_STACK_FLOOR, 13'd128);
    random_phase(110);
    write_cfg(CFG_MEM_IN_USE, 13'd4096);
    write_cfg(CFG_STACK_FLOOR, 13'd4000);
    random_phase(110);

    // faults are sticky, so the one that ends the program comes last
    write_cfg(CFG_STACK_FLOOR, 13'd4096);
    tries = 0;
    while (!vm_stopped && tries < 40) begin
      program_and_run(1'b1);
      tries++;
    end
    if (!vm_stopped) begin
      send_beat(CMD_WRITE, vm_pc[11:0], OP_HALT);
      send_beat(CMD_EXEC, 12'd0, 8'd0);
    end
    write_cfg(CFG_MEM_IN_USE, 13'd4);
    write_cfg(CFG_STACK_FLOOR, 13'd0);
    repeat (10) begin
      noise_beat();
      send_beat(CMD_EXEC, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
    end

    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d beats (%0d executes, %0d prints), %0d results checked",
             n_items, n_exec, n_prints, n_results);
    $display("memory sizes 4096/256/4, stack floors 0/128/4000/4096, final flags %0h",
             vm_flags);
    if (mismatches == 0 && pending_steps.size() == 0) begin
      $display("** bytecode_vm_step_core: PASSED **");
    end else begin
      $display("** bytecode_vm_step_core: FAILED **");
    end
    $finish;
  end

endmodule
